[rtl/gblur_pkg.sv]
// ----------------------------------------------------------------------------
// Gaussian blur package
// Shared sizes, pixel and window types, kernel weights and the frame size
// clamp used by the 5x5 RGB Gaussian blur.
// ----------------------------------------------------------------------------
package gblur_pkg;

  // Frame limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 5;

  // Register and counter widths
  localparam int DIM_W  = 11;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int DIFF_W = $clog2(2 * MAX_WIDTH + 4);
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Pixel and window geometry
  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int PIX_W  = CH_W * NUM_CH;
  localparam int WIN    = 5;
  localparam int MID    = WIN / 2;
  localparam int LANES  = WIN - 1;

  // Arithmetic widths: a row of the kernel sums to at most 49 * 255,
  // the whole kernel to 159 * 255
  localparam int ROWSUM_W = 14;
  localparam int ACC_W    = 16;
  localparam int PROD_W   = 32;

  // Division by 159 as multiplication by ceil(2^23 / 159), exact below 114913
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_159   = 52759;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  typedef logic [PIX_W-1:0]          pix_t;
  typedef pix_t [LANES-1:0]          lanes_t;
  typedef pix_t [WIN-1:0][WIN-1:0]   win_t;
  typedef logic [3:0]                weight_t;

  // Kernel, rows by columns
  localparam weight_t GAUSS_W [WIN][WIN] = '{
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
  };

  // Per-result flags that travel with the window through the filter
  typedef struct packed {
    logic border;
    logic last;
  } tag_t;

  // Clamp a programmed frame dimension into the supported range
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v < DIM_W'(MIN_DIM)) begin
      r = DIM_W'(MIN_DIM);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/gblur_filter.sv]
// ----------------------------------------------------------------------------
// Gaussian blur filter datapath
// Three register stages: kernel row sums, kernel total, divide by 159 and
// border select into the output register.
// ----------------------------------------------------------------------------
module gblur_filter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_vld_i,
  output logic              in_rdy_o,
  input  gblur_pkg::win_t   win_i,
  input  gblur_pkg::tag_t   tag_i,
  output logic              out_vld_o,
  input  logic              out_rdy_i,
  output gblur_pkg::pix_t   out_pix_o,
  output logic              out_last_o
);
  import gblur_pkg::*;

  logic                s2_vld_q, s3_vld_q, s4_vld_q;
  logic                s2_rdy, s3_rdy, s4_rdy;
  logic [ROWSUM_W-1:0] rsum_d [NUM_CH][WIN];
  logic [ROWSUM_W-1:0] rsum_q [NUM_CH][WIN];
  logic [ACC_W-1:0]    acc_d  [NUM_CH];
  logic [ACC_W-1:0]    acc_q  [NUM_CH];
  logic [PROD_W-1:0]   prod   [NUM_CH];
  pix_t                quot;
  pix_t                s2_mid_q, s3_mid_q;
  tag_t                s2_tag_q, s3_tag_q;
  pix_t                out_pix_q;
  logic                out_last_q;

  // Stall a stage only while the one after it is full and held
  assign s4_rdy   = !s4_vld_q || out_rdy_i;
  assign s3_rdy   = !s3_vld_q || s4_rdy;
  assign s2_rdy   = !s2_vld_q || s3_rdy;
  assign in_rdy_o = s2_rdy;

  // Weighted sum along each kernel row
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int r = 0; r < WIN; r++) begin
        rsum_d[ch][r] = '0;
        for (int c = 0; c < WIN; c++) begin
          rsum_d[ch][r] = rsum_d[ch][r]
                        + ROWSUM_W'(win_i[r][c][CH_W*ch +: CH_W])
                        * ROWSUM_W'(GAUSS_W[r][c]);
        end
      end
    end
  end

  // Add the five row sums
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc_d[ch] = '0;
      for (int r = 0; r < WIN; r++) begin
        acc_d[ch] = acc_d[ch] + ACC_W'(rsum_q[ch][r]);
      end
    end
  end

  // Divide by 159 through the reciprocal
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = PROD_W'(acc_q[ch]) * PROD_W'(RECIP_159);
      quot[CH_W*ch +: CH_W] = prod[ch][RECIP_SHIFT +: CH_W];
    end
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (s2_rdy) s2_vld_q <= in_vld_i;
      if (s3_rdy) s3_vld_q <= s2_vld_q;
      if (s4_rdy) s4_vld_q <= s3_vld_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_vld_i && s2_rdy) begin
      rsum_q   <= rsum_d;
      s2_mid_q <= win_i[MID][MID];
      s2_tag_q <= tag_i;
    end
    if (s2_vld_q && s3_rdy) begin
      acc_q    <= acc_d;
      s3_mid_q <= s2_mid_q;
      s3_tag_q <= s2_tag_q;
    end
    if (s3_vld_q && s4_rdy) begin
      // Pass the centre pixel unchanged near the frame edges
      out_pix_q  <= s3_tag_q.border ? s3_mid_q : quot;
      out_last_q <= s3_tag_q.last;
    end
  end

  assign out_vld_o  = s4_vld_q;
  assign out_pix_o  = out_pix_q;
  assign out_last_o = out_last_q;

endmodule

[rtl/gaussian_blur_5x5_rgb.sv]
// ----------------------------------------------------------------------------
// 5x5 Gaussian blur on an RGB pixel stream
// Raster-order pixels in, blurred pixels out two rows and two columns
// behind; border pixels pass through; flush requests drain the frame tail.
//
//   Channel   Dir   Payload                                       Handshake
//   s_axis    in    tdata: red, green, blue; tuser: start, flush   tvalid/tready
//   m_axis    out   tdata: red, green, blue; tlast: frame end      tvalid/tready
//   apb       in    reg 0 width at 0x0, reg 1 height at 0x4        psel/penable
//
// One request per clock while s_axis_tready is high. A released result passes
// the feed register, loaded with the line memory and window update, then the
// filter stages. Reset is asynchronous and clears all control state; the
// line memory is not cleared and needs no clearing pass. A held m_axis_tready
// stalls every stage and drops s_axis_tready once the pipeline is full.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_rgb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Pixel requests
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gblur_pkg::PIX_W-1:0]   s_axis_tdata,   // in_red, in_green, in_blue
  input  logic [1:0]                    s_axis_tuser,   // frame_start, flush
  // Blurred pixels
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [gblur_pkg::PIX_W-1:0]   m_axis_tdata,   // out_red, out_green, out_blue
  output logic                          m_axis_tlast,
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gblur_pkg::ADDR_W-1:0]  paddr,
  input  logic [gblur_pkg::DATA_W-1:0]  pwdata,
  output logic [gblur_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import gblur_pkg::*;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  localparam int FLAG_START = 0;
  localparam int FLAG_FLUSH = 1;

  logic [DIM_W-1:0]  cfg_width_q, cfg_height_q;
  logic              cfg_wr;
  reg_e              cfg_sel;

  logic [DIM_W-1:0]  fw_q, fw_d, fh_q, fh_d;
  logic [COL_W-1:0]  in_col_q, in_col_d, in_col_b;
  logic [ROW_W-1:0]  in_row_q, in_row_d, in_row_b;
  logic [COL_W-1:0]  out_col_q, out_col_d, out_col_b;
  logic [ROW_W-1:0]  out_row_q, out_row_d, out_row_b;
  logic [DIFF_W-1:0] diff_q, diff_d, diff_b, diff_w, lag;
  logic [COL_W-1:0]  push_col_q, push_col_d, push_col_b;

  logic              accept, is_flush, begin_frame, write, emit, push;
  tag_t              tag;

  lanes_t            line_mem [MAX_WIDTH];
  lanes_t            lanes_rd_q, lanes_wr;
  pix_t              new_col [WIN];
  win_t              win_q;

  logic              s1_vld_q, s1_rdy;
  tag_t              s1_tag_q;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = reg_e'(paddr[ADDR_W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_RST;
      cfg_height_q <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_WIDTH:  cfg_width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_height_q <= pwdata[DIM_W-1:0];
        default:    cfg_width_q  <= cfg_width_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_WIDTH:  prdata = DATA_W'(cfg_width_q);
      REG_HEIGHT: prdata = DATA_W'(cfg_height_q);
      default:    prdata = '0;
    endcase
  end

  // ------------------------------------------------------ frame sequencing
  assign s_axis_tready = s1_rdy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_flush      = s_axis_tuser[FLAG_FLUSH];
  assign write         = accept && !is_flush;

  // Start a frame on a marked pixel, the first pixel ever, or after a full frame
  assign begin_frame = write && (s_axis_tuser[FLAG_START] ||
                                 (in_col_q == '0 && in_row_q == '0) ||
                                 (DIM_W'(in_row_q) == fh_q));

  assign fw_d       = begin_frame ? clamp_dim(cfg_width_q,  DIM_W'(MAX_WIDTH))  : fw_q;
  assign fh_d       = begin_frame ? clamp_dim(cfg_height_q, DIM_W'(MAX_HEIGHT)) : fh_q;
  assign in_col_b   = begin_frame ? '0 : in_col_q;
  assign in_row_b   = begin_frame ? '0 : in_row_q;
  assign out_col_b  = begin_frame ? '0 : out_col_q;
  assign out_row_b  = begin_frame ? '0 : out_row_q;
  assign diff_b     = begin_frame ? '0 : diff_q;
  assign push_col_b = begin_frame ? '0 : push_col_q;

  // Results wait until the pixel two rows and two columns further is in
  assign lag = DIFF_W'({fw_d, 1'b0}) + DIFF_W'(2);

  always_comb begin
    // Advance the input position
    in_col_d = in_col_b;
    in_row_d = in_row_b;
    if (write) begin
      if (DIM_W'(in_col_b) == fw_d - DIM_W'(1)) begin
        in_col_d = '0;
        in_row_d = in_row_b + ROW_W'(1);
      end else begin
        in_col_d = in_col_b + COL_W'(1);
      end
    end
    diff_w = write ? diff_b + DIFF_W'(1) : diff_b;

    // Release a result once far enough behind, or freely once the frame is in
    emit = accept && (DIM_W'(out_row_b) != fh_d) &&
           ((diff_w > lag) || (DIM_W'(in_row_d) == fh_d));

    out_col_d = out_col_b;
    out_row_d = out_row_b;
    diff_d    = diff_w;
    if (emit) begin
      diff_d = diff_w - DIFF_W'(1);
      if (DIM_W'(out_col_b) == fw_d - DIM_W'(1)) begin
        out_col_d = '0;
        out_row_d = out_row_b + ROW_W'(1);
      end else begin
        out_col_d = out_col_b + COL_W'(1);
      end
    end

    tag.border = (out_row_b < ROW_W'(2)) || (out_col_b < COL_W'(2)) ||
                 (DIM_W'(out_row_b) >= fh_d - DIM_W'(2)) ||
                 (DIM_W'(out_col_b) >= fw_d - DIM_W'(2));
    tag.last   = (DIM_W'(out_row_b) == fh_d - DIM_W'(1)) &&
                 (DIM_W'(out_col_b) == fw_d - DIM_W'(1));

    // Drain results push a dummy pixel so the window centre keeps pace
    push       = write || emit;
    push_col_d = push_col_b;
    if (push) begin
      push_col_d = (DIM_W'(push_col_b) == fw_d - DIM_W'(1)) ? '0
                                                           : push_col_b + COL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= WIDTH_RST;
      fh_q       <= HEIGHT_RST;
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      diff_q     <= '0;
      push_col_q <= '0;
    end else begin
      fw_q       <= fw_d;
      fh_q       <= fh_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      diff_q     <= diff_d;
      push_col_q <= push_col_d;
    end
  end

  // ------------------------------------------------- line memory and window
  // One entry per column holds that column of the four rows above
  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      new_col[r] = lanes_rd_q[r];
    end
    new_col[WIN-1] = s_axis_tdata;
    for (int r = 0; r < LANES; r++) begin
      lanes_wr[r] = new_col[r+1];
    end
  end

  // Read ahead at the next column so the entry is ready for the next request
  always_ff @(posedge clk_i) begin
    if (push) begin
      line_mem[push_col_b] <= lanes_wr;
    end
    lanes_rd_q <= line_mem[push_col_d];
  end

  // Shift the window one column left and take in the new column
  always_ff @(posedge clk_i) begin
    if (push) begin
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN - 1; c++) begin
          win_q[r][c] <= win_q[r][c+1];
        end
        win_q[r][WIN-1] <= new_col[r];
      end
    end
  end

  // ------------------------------------------------------------ filter feed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_tag_q <= tag;
    end
  end

  logic filt_rdy;

  assign s1_rdy = !s1_vld_q || filt_rdy;

  gblur_filter u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (s1_vld_q),
    .in_rdy_o   (filt_rdy),
    .win_i      (win_q),
    .tag_i      (s1_tag_q),
    .out_vld_o  (m_axis_tvalid),
    .out_rdy_i  (m_axis_tready),
    .out_pix_o  (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

[rtl/gblur_checker.sv]
// ----------------------------------------------------------------------------
// Gaussian blur port checker
// Watches the ports of the blur block for stall, latency and register
// behaviour, attached by bind.
// ----------------------------------------------------------------------------
module gblur_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [gblur_pkg::PIX_W-1:0]   s_axis_tdata,   // in_red, in_green, in_blue
  input logic [1:0]                    s_axis_tuser,   // frame_start, flush
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [gblur_pkg::PIX_W-1:0]   m_axis_tdata,   // out_red, out_green, out_blue
  input logic                          m_axis_tlast,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [gblur_pkg::ADDR_W-1:0]  paddr,
  input logic [gblur_pkg::DATA_W-1:0]  pwdata,
  input logic [gblur_pkg::DATA_W-1:0]  prdata,
  input logic                          pready
);
  import gblur_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Drop requests only when every stage is full and the output is held
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a held output");

  // A fresh result must follow an accepted request
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 4))
    else $error("result appeared without a matching request");

  // Read back a width just written
  a_width_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[ADDR_W-1]) ##1
      (psel && !pwrite && !paddr[ADDR_W-1]) |->
      prdata == DATA_W'($past(pwdata[DIM_W-1:0])))
    else $error("width register read back wrong");

endmodule

bind gaussian_blur_5x5_rgb gblur_checker u_gblur_checker (.*);
